// File: design/itst_pkg.sv
// Shared types and constants for the temperature sensor thermostat.
`default_nettype none
package itst_pkg;

  typedef logic signed [8:0] temp_t;

  typedef enum logic [2:0] {
    OP_START_WRITE = 3'd0,
    OP_START_READ  = 3'd1,
    OP_WRITE_BYTE  = 3'd2,
    OP_READ_BYTE   = 3'd3,
    OP_STOP        = 3'd4,
    OP_POLL_TICK   = 3'd5,
    OP_NEW_TEMP    = 3'd6,
    OP_UNUSED      = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    PTR_TEMP   = 2'd0,
    PTR_CONFIG = 2'd1,
    PTR_HIGH   = 2'd2,
    PTR_HYST   = 2'd3
  } pointer_t;

  localparam int unsigned CFG_SHUTDOWN_BIT = 0;
  localparam int unsigned CFG_INTMODE_BIT  = 1;

  localparam temp_t TEMP_MIN       = 9'sb110010010;
  localparam temp_t TEMP_MAX       = 9'sb011111010;
  localparam temp_t TEMP_RESET     = 9'sd45;
  localparam temp_t HIGH_RESET     = 9'sd160;
  localparam temp_t HYST_RESET     = 9'sd150;
  localparam logic [7:0] BYTE_NONE = 8'hff;

endpackage
`default_nettype wire

// File: design/i2c_temp_sensor_thermostat.sv
// Top level: register side and thermostat alarm of an I2C temperature sensor.
`default_nettype none
// Each input word is one bus event (start write, start read, written byte,
// read byte, stop), a poll tick or a new sensor reading, and it produces
// exactly one output word: the read data (zero unless the event was a byte
// read, 0xff once the two-byte transfer buffer is used up) and the alarm
// level after the event. A word is captured in an input register; a short
// block of logic then updates the pointer, config, limits, transfer buffer
// and alarm and loads the output register once that register can take it.
// The block takes one word per clock cycle while the output is not stalled;
// the output register stalls the input side only when a result is waiting
// and out_stall is high. Temperatures are 9-bit signed half-degree values;
// limits are compared as signed values. In interrupt mode a read start
// clears the alarm, and the shutdown bit holds the alarm low.
module i2c_temp_sensor_thermostat (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [2:0]      in_opcode,
  input  wire logic [7:0]      in_write_byte,
  input  wire itst_pkg::temp_t in_sensor_temp,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           out_read_byte,
  output logic                 out_alarm_level
);
  import itst_pkg::*;

  // Input register.
  logic        s1_valid_r;
  opcode_t     s1_op_r;
  logic [7:0]  s1_byte_r;
  temp_t       s1_temp_r;

  // Output register.
  logic        out_valid_r;
  logic [7:0]  out_read_byte_r, out_read_byte_nxt;
  logic        out_alarm_r;

  // Architectural state.
  logic [1:0]  ptr_r, ptr_nxt;
  logic [7:0]  cfg_r, cfg_nxt;
  temp_t       temp_r, temp_nxt;
  temp_t       high_r, high_nxt;
  temp_t       hyst_r, hyst_nxt;
  logic [7:0]  buf0_r, buf0_nxt;
  logic [7:0]  buf1_r, buf1_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        event_r, event_nxt;
  logic        alarm_r, alarm_nxt;

  logic        out_ready;
  logic        s1_fire;
  logic        in_fire;
  logic        do_eval;
  temp_t       joined;

  // The output register can take a new word when it is empty or being drained.
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_fire   = in_valid && !in_stall;

  assign out_valid       = out_valid_r;
  assign out_read_byte   = out_read_byte_r;
  assign out_alarm_level = out_alarm_r;

  always_comb begin
    ptr_nxt           = ptr_r;
    cfg_nxt           = cfg_r;
    temp_nxt          = temp_r;
    high_nxt          = high_r;
    hyst_nxt          = hyst_r;
    buf0_nxt          = buf0_r;
    buf1_nxt          = buf1_r;
    count_nxt         = count_r;
    event_nxt         = event_r;
    alarm_nxt         = alarm_r;
    out_read_byte_nxt = 8'h00;
    do_eval           = 1'b0;
    joined            = temp_t'({buf0_r, buf1_r[7]});

    case (s1_op_r)
      OP_START_WRITE: begin
        count_nxt = 2'd0;
      end
      OP_START_READ: begin
        // Reload the transfer buffer from the pointed register.
        case (pointer_t'(ptr_r))
          PTR_TEMP: begin
            buf0_nxt = temp_r[8:1];
            buf1_nxt = {temp_r[0], 7'd0};
          end
          PTR_CONFIG: begin
            buf0_nxt = cfg_r;
            buf1_nxt = BYTE_NONE;
          end
          PTR_HIGH: begin
            buf0_nxt = high_r[8:1];
            buf1_nxt = {high_r[0], 7'd0};
          end
          default: begin
            buf0_nxt = hyst_r[8:1];
            buf1_nxt = {hyst_r[0], 7'd0};
          end
        endcase
        if (cfg_r[CFG_INTMODE_BIT]) begin
          alarm_nxt = 1'b0;
        end
        count_nxt = 2'd0;
      end
      OP_WRITE_BYTE: begin
        if (count_r == 2'd0) begin
          ptr_nxt   = s1_byte_r[1:0];
          count_nxt = 2'd1;
        end else if (count_r != 2'd3) begin
          if (count_r == 2'd1) begin
            buf0_nxt = s1_byte_r;
          end else begin
            buf1_nxt = s1_byte_r;
          end
          joined = temp_t'({buf0_nxt, buf1_nxt[7]});
          case (pointer_t'(ptr_r))
            PTR_TEMP:   ;
            PTR_CONFIG: cfg_nxt = buf0_nxt;
            PTR_HIGH:   high_nxt = joined;
            default:    hyst_nxt = joined;
          endcase
          do_eval   = 1'b1;
          count_nxt = count_r + 2'd1;
        end
      end
      OP_READ_BYTE: begin
        if (count_r < 2'd2) begin
          out_read_byte_nxt = count_r[0] ? buf1_r : buf0_r;
          count_nxt         = count_r + 2'd1;
        end else begin
          out_read_byte_nxt = BYTE_NONE;
        end
      end
      OP_POLL_TICK: begin
        do_eval = 1'b1;
      end
      OP_NEW_TEMP: begin
        if (s1_temp_r < TEMP_MIN) begin
          temp_nxt = TEMP_MIN;
        end else if (s1_temp_r > TEMP_MAX) begin
          temp_nxt = TEMP_MAX;
        end else begin
          temp_nxt = s1_temp_r;
        end
      end
      default: ;
    endcase

    // Thermostat evaluation with the freshly written config and limits.
    if (do_eval) begin
      if (cfg_nxt[CFG_SHUTDOWN_BIT]) begin
        alarm_nxt = 1'b0;
      end else if (cfg_nxt[CFG_INTMODE_BIT]) begin
        if (!event_r && (temp_r > high_nxt)) begin
          event_nxt = 1'b1;
          alarm_nxt = 1'b1;
        end else if (event_r && (temp_r < hyst_nxt)) begin
          event_nxt = 1'b0;
          alarm_nxt = 1'b1;
        end
      end else begin
        if (temp_r > high_nxt) begin
          alarm_nxt = 1'b1;
        end
        if (temp_r < hyst_nxt) begin
          alarm_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ptr_r       <= 2'd0;
      cfg_r       <= 8'h00;
      temp_r      <= TEMP_RESET;
      high_r      <= HIGH_RESET;
      hyst_r      <= HYST_RESET;
      buf0_r      <= BYTE_NONE;
      buf1_r      <= BYTE_NONE;
      count_r     <= 2'd0;
      event_r     <= 1'b0;
      alarm_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        ptr_r       <= ptr_nxt;
        cfg_r       <= cfg_nxt;
        temp_r      <= temp_nxt;
        high_r      <= high_nxt;
        hyst_r      <= hyst_nxt;
        buf0_r      <= buf0_nxt;
        buf1_r      <= buf1_nxt;
        count_r     <= count_nxt;
        event_r     <= event_nxt;
        alarm_r     <= alarm_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= opcode_t'(in_opcode);
      s1_byte_r <= in_write_byte;
      s1_temp_r <= in_sensor_temp;
    end
    if (s1_fire) begin
      out_read_byte_r <= out_read_byte_nxt;
      out_alarm_r     <= alarm_nxt;
    end
  end

  // Shutdown always holds the alarm low.
  a_shutdown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_r[CFG_SHUTDOWN_BIT] |-> !alarm_r)
    else $error("alarm active while in shutdown");

  // The input side only stalls when a word sits in the input register.
  a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // Only byte reads return nonzero data.
  a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_op_r != OP_READ_BYTE)) |=> (out_read_byte_r == 8'h00))
    else $error("nonzero read data for a non-read word");

  // Stops, write starts and new readings never move the alarm.
  a_alarm_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && ((s1_op_r == OP_START_WRITE) || (s1_op_r == OP_STOP) ||
                 (s1_op_r == OP_NEW_TEMP))) |=> $stable(alarm_r))
    else $error("alarm changed on a word that does not evaluate it");

endmodule
`default_nettype wire

// File: verif/i2c_temp_sensor_thermostat_tb.sv
// Self-checking testbench for the I2C temperature sensor thermostat register block.
`default_nettype none
module i2c_temp_sensor_thermostat_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itst_pkg::*;

  // The run stops with a failure if it ever takes more than this many cycles. The
  // slowest correct run is about a thousand words with both sides idling,
  // so this is far beyond it.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_WORDS = 800;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One output word: the byte returned by a read and the alarm level.
  typedef struct packed {
    logic [7:0] read_byte;
    logic       alarm_level;
  } sensor_reply_t;

  // One row of the directed part. Where known is set, the reply is typed in
  // by hand; otherwise the thermostat model works it out.
  typedef struct packed {
    opcode_t    op;
    logic [7:0] wr_byte;
    temp_t      sensor;
    bit         known;
    logic [7:0] read_byte;
    logic       alarm_level;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  opcode_t    in_opcode;
  logic [7:0] in_write_byte;
  temp_t      in_sensor_temp;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_read_byte;
  logic       out_alarm_level;

  i2c_temp_sensor_thermostat dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_write_byte  (in_write_byte),
    .in_sensor_temp (in_sensor_temp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_byte  (out_read_byte),
    .out_alarm_level(out_alarm_level)
  );

  always #5 clk = ~clk;

  // Replies still owed by the block, oldest first.
  sensor_reply_t reply_queue [$];
  sensor_reply_t oldest_reply;
  int unsigned   mismatches;
  int unsigned   cycle_count;
  int unsigned   words_sent;
  // Cleared during a stretch of the random part so that both sides run
  // back to back for about two hundred words.
  bit            idle_on;

  // Thermostat state as the testbench tracks it.
  pointer_t   ptr_q;
  logic [7:0] cfg_q;
  temp_t      temp_q;
  temp_t      high_q;
  temp_t      hyst_q;
  logic [7:0] xfer_q [2];
  logic [1:0] count_q;
  logic       event_q;
  logic       alarm_q;

  // The directed part: reads of the buffer as it stands after reset and a
  // read past its end, a pointer-zero read of the reset temperature, stop
  // and the unused opcode, sensor values clamped at both ends, comparator
  // mode on the reset limits, then a config write with an extra byte that
  // must be ignored, and the interrupt mode alarm being raised on the high
  // limit, cleared by a read start and raised again on the way back down.
  stim_row_t directed_rows [25] = '{
    '{OP_READ_BYTE,   8'h00, 9'h000, 1'b1, 8'hff, 1'b0},
    '{OP_READ_BYTE,   8'hff, 9'h1ff, 1'b1, 8'hff, 1'b0},
    '{OP_READ_BYTE,   8'h00, 9'h000, 1'b1, 8'hff, 1'b0},
    '{OP_START_READ,  8'h00, 9'h000, 1'b1, 8'h00, 1'b0},
    '{OP_READ_BYTE,   8'h00, 9'h000, 1'b1, 8'h16, 1'b0},
    '{OP_READ_BYTE,   8'h00, 9'h000, 1'b1, 8'h80, 1'b0},
    '{OP_STOP,        8'hff, 9'h1ff, 1'b1, 8'h00, 1'b0},
    '{OP_UNUSED,      8'hff, 9'h0ff, 1'b1, 8'h00, 1'b0},
    '{OP_NEW_TEMP,    8'h00, 9'h0ff, 1'b1, 8'h00, 1'b0},
    '{OP_POLL_TICK,   8'h00, 9'h000, 1'b1, 8'h00, 1'b1},
    '{OP_NEW_TEMP,    8'h00, 9'h100, 1'b1, 8'h00, 1'b1},
    '{OP_POLL_TICK,   8'h00, 9'h000, 1'b1, 8'h00, 1'b0},
    '{OP_START_WRITE, 8'h00, 9'h000, 1'b0, 8'h00, 1'b0},
    '{OP_WRITE_BYTE,  8'hfd, 9'h000, 1'b0, 8'h00, 1'b0},
    '{OP_WRITE_BYTE,  8'h02, 9'h000, 1'b0, 8'h00, 1'b0},
    '{OP_WRITE_BYTE,  8'h55, 9'h000, 1'b0, 8'h00, 1'b0},
    '{OP_WRITE_BYTE,  8'haa, 9'h000, 1'b0, 8'h00, 1'b0},
    '{OP_STOP,        8'h00, 9'h000, 1'b0, 8'h00, 1'b0},
    '{OP_NEW_TEMP,    8'h00, 9'd200, 1'b0, 8'h00, 1'b0},
    '{OP_POLL_TICK,   8'h00, 9'h000, 1'b0, 8'h00, 1'b0},
    '{OP_START_READ,  8'h00, 9'h000, 1'b0, 8'h00, 1'b0},
    '{OP_READ_BYTE,   8'h00, 9'h000, 1'b0, 8'h00, 1'b0},
    '{OP_READ_BYTE,   8'h00, 9'h000, 1'b0, 8'h00, 1'b0},
    '{OP_NEW_TEMP,    8'h00, 9'd100, 1'b0, 8'h00, 1'b0},
    '{OP_POLL_TICK,   8'h00, 9'h000, 1'b0, 8'h00, 1'b0}
  };

  function automatic void reset_thermostat();
    ptr_q     = PTR_TEMP;
    cfg_q     = 8'h00;
    temp_q    = TEMP_RESET;
    high_q    = HIGH_RESET;
    hyst_q    = HYST_RESET;
    xfer_q[0] = BYTE_NONE;
    xfer_q[1] = BYTE_NONE;
    count_q   = 2'd0;
    event_q   = 1'b0;
    alarm_q   = 1'b0;
  endfunction

  // Thermostat decision. All three values are signed half degrees, so the
  // compares below are signed compares.
  function automatic void update_alarm();
    if (cfg_q[CFG_SHUTDOWN_BIT]) begin
      alarm_q = 1'b0;
    end else if (cfg_q[CFG_INTMODE_BIT]) begin
      if (!event_q && temp_q > high_q) begin
        event_q = 1'b1;
        alarm_q = 1'b1;
      end else if (event_q && temp_q < hyst_q) begin
        event_q = 1'b0;
        alarm_q = 1'b1;
      end
    end else begin
      if (temp_q > high_q) alarm_q = 1'b1;
      if (temp_q < hyst_q) alarm_q = 1'b0;
    end
  endfunction

  // Works out the reply to one accepted word and advances the state.
  function automatic sensor_reply_t thermostat_reply(opcode_t op, logic [7:0] wr_byte,
                                                     temp_t sensor);
    sensor_reply_t reply;
    temp_t         stored;
    reply.read_byte = 8'h00;
    case (op)
      OP_START_WRITE: begin
        count_q = 2'd0;
      end
      OP_START_READ: begin
        // A 9-bit value goes out as bits 8..1, then bit 0 in the top bit.
        case (ptr_q)
          PTR_TEMP:   stored = temp_q;
          PTR_HIGH:   stored = high_q;
          default:    stored = hyst_q;
        endcase
        if (ptr_q == PTR_CONFIG) begin
          xfer_q[0] = cfg_q;
          xfer_q[1] = BYTE_NONE;
        end else begin
          xfer_q[0] = stored[8:1];
          xfer_q[1] = {stored[0], 7'd0};
        end
        if (cfg_q[CFG_INTMODE_BIT]) alarm_q = 1'b0;
        count_q = 2'd0;
      end
      OP_WRITE_BYTE: begin
        if (count_q == 2'd0) begin
          ptr_q   = pointer_t'(wr_byte[1:0]);
          count_q = 2'd1;
        end else if (count_q != 2'd3) begin
          // Each of the first two data bytes commits the buffer to the pointed config or limit register;
          // the temperature register is not written. A count of one fills entry 0 and a count of two fills entry 1.
          xfer_q[count_q[1]] = wr_byte;
          case (ptr_q)
            PTR_CONFIG: cfg_q  = xfer_q[0];
            PTR_HIGH:   high_q = {xfer_q[0], xfer_q[1][7]};
            PTR_HYST:   hyst_q = {xfer_q[0], xfer_q[1][7]};
            default:    ;
          endcase
          update_alarm();
          count_q = count_q + 2'd1;
        end
      end
      OP_READ_BYTE: begin
        if (count_q < 2'd2) begin
          reply.read_byte = xfer_q[count_q[0]];
          count_q = count_q + 2'd1;
        end else begin
          reply.read_byte = BYTE_NONE;
        end
      end
      OP_POLL_TICK: begin
        update_alarm();
      end
      OP_NEW_TEMP: begin
        if (sensor < TEMP_MIN) temp_q = TEMP_MIN;
        else if (sensor > TEMP_MAX) temp_q = TEMP_MAX;
        else temp_q = sensor;
      end
      default: ;
    endcase
    reply.alarm_level = alarm_q;
    return reply;
  endfunction

  // A temperature inside the sensor's range, used for readings and limits.
  function automatic temp_t random_temp();
    return temp_t'($urandom_range(360)) - temp_t'(110);
  endfunction

  // Offers one word at the falling edge, possibly after random idle cycles,
  // and holds it until the block takes it at a rising edge. The reply is
  // queued once the word is accepted.
  task automatic send_word(input opcode_t op, input logic [7:0] wr_byte, input temp_t sensor,
                           input bit known = 1'b0,
                           input sensor_reply_t typed_reply = '0);
    sensor_reply_t predicted;
    while (idle_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_write_byte  <= wr_byte;
    in_sensor_temp <= sensor;
    do @(posedge clk); while (in_stall);
    predicted = thermostat_reply(op, wr_byte, sensor);
    reply_queue.push_back(known ? typed_reply : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  // A register write as a bus master does it: start, pointer byte, up to
  // three data bytes (the third is ignored), and usually a stop. Limits are
  // sent as a proper high and low byte pair with random filler bits.
  task automatic write_transaction();
    pointer_t    ptr;
    int unsigned data_bytes;
    temp_t       limit;
    logic [7:0]  data;
    ptr        = pointer_t'($urandom_range(3));
    data_bytes = $urandom_range(3);
    limit      = random_temp();
    send_word(OP_START_WRITE, 8'($urandom), temp_t'($urandom));
    send_word(OP_WRITE_BYTE, {6'($urandom), ptr}, temp_t'($urandom));
    for (int unsigned i = 0; i < data_bytes; i++) begin
      data = 8'($urandom);
      if (i == 0 && ptr == PTR_CONFIG) begin
        // Shutdown only now and then, or the alarm would sit low too often.
        data[CFG_SHUTDOWN_BIT] = ($urandom_range(99) < 15);
      end else if (i == 0 && (ptr == PTR_HIGH || ptr == PTR_HYST)) begin
        data = limit[8:1];
      end else if (i == 1 && (ptr == PTR_HIGH || ptr == PTR_HYST)) begin
        data[7] = limit[0];
      end
      send_word(OP_WRITE_BYTE, data, temp_t'($urandom));
    end
    if ($urandom_range(9) != 0) send_word(OP_STOP, 8'($urandom), temp_t'($urandom));
  endtask

  // A register read: an optional pointer set, a read start, zero to three
  // byte reads (the third runs past the buffer), and a stop.
  task automatic read_transaction();
    int unsigned reads;
    reads = $urandom_range(3);
    if ($urandom_range(1)) begin
      send_word(OP_START_WRITE, 8'($urandom), temp_t'($urandom));
      send_word(OP_WRITE_BYTE, 8'($urandom), temp_t'($urandom));
      if ($urandom_range(1)) send_word(OP_STOP, 8'($urandom), temp_t'($urandom));
    end
    send_word(OP_START_READ, 8'($urandom), temp_t'($urandom));
    for (int unsigned i = 0; i < reads; i++) begin
      send_word(OP_READ_BYTE, 8'($urandom), temp_t'($urandom));
    end
    send_word(OP_STOP, 8'($urandom), temp_t'($urandom));
  endtask

  // The receiver stalls at random, decided at each falling edge.
  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 7);
  end

  // Every accepted output word is matched against the oldest reply owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reply_queue.size() == 0) begin
        $error("output word with no reply expected: read_byte %h alarm_level %b",
               out_read_byte, out_alarm_level);
        mismatches++;
      end else begin
        oldest_reply = reply_queue.pop_front();
        if (out_read_byte !== oldest_reply.read_byte) begin
          $error("read_byte: expected %h, actual %h", oldest_reply.read_byte, out_read_byte);
          mismatches++;
        end
        if (out_alarm_level !== oldest_reply.alarm_level) begin
          $error("alarm_level: expected %b, actual %b", oldest_reply.alarm_level,
                 out_alarm_level);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_STOP;
    in_write_byte  = 8'h00;
    in_sensor_temp = '0;
    out_stall      = 1'b0;
    idle_on        = 1'b1;
    mismatches     = 0;
    cycle_count    = 0;
    words_sent     = 0;
    reset_thermostat();

    // Synchronous reset held low, then released at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].wr_byte, directed_rows[i].sensor,
                directed_rows[i].known,
                '{directed_rows[i].read_byte, directed_rows[i].alarm_level});
    end

    // Random part: mostly well-formed bus transactions with random content,
    // mixed with sensor readings, poll ticks and a share of raw noise words.
    // Idling on both sides pauses for a stretch in the middle.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      idle_on = !(words_sent >= 350 && words_sent < 550);
      pick = $urandom_range(99);
      if (pick < 30) begin
        write_transaction();
      end else if (pick < 55) begin
        read_transaction();
      end else if (pick < 70) begin
        // A fifth of the readings use the whole 9-bit range to hit clamping.
        send_word(OP_NEW_TEMP, 8'($urandom),
                  ($urandom_range(4) == 0) ? temp_t'($urandom) : random_temp());
      end else if (pick < 85) begin
        send_word(OP_POLL_TICK, 8'($urandom), temp_t'($urandom));
      end else begin
        send_word(opcode_t'($urandom_range(6)), 8'($urandom), temp_t'($urandom));
      end
    end
    in_valid <= 1'b0;
    idle_on = 1'b1;

    // Wait for every reply, then wait on for the drain period to catch stray words.
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && reply_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: i2c_temp_sensor_thermostat.f
design/itst_pkg.sv
design/i2c_temp_sensor_thermostat.sv
verif/i2c_temp_sensor_thermostat_tb.sv
